// ===== hdl/iidl_pkg.sv =====
// Shared command codes, cell select codes and field widths for the indexed list.
`default_nettype none

package iidl_pkg;

    // Command codes carried on the command field
    typedef enum logic [2:0] {
        CMD_INS_TAIL = 3'd0,
        CMD_INS_HEAD = 3'd1,
        CMD_INS_AT   = 3'd2,
        CMD_REM_HEAD = 3'd3,
        CMD_REM_TAIL = 3'd4,
        CMD_REM_AT   = 3'd5,
        CMD_READ_AT  = 3'd6
    } t_cmd;

    // What one storage cell loads at the next edge
    typedef enum logic [1:0] {
        SEL_HOLD  = 2'd0,
        SEL_NEW   = 2'd1,
        SEL_LEFT  = 2'd2,
        SEL_RIGHT = 2'd3
    } t_cell_sel;

    // Fixed widths of the request and response fields
    localparam int POS_W   = 4;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 5;

endpackage : iidl_pkg

`default_nettype wire

// ===== hdl/iidl_cell.sv =====
// One storage cell of the list: holds a word, or takes a new word or a neighbor's word.
`default_nettype none

module iidl_cell
    import iidl_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire t_cell_sel             i_sel,
    input  wire logic [DATA_WIDTH-1:0] i_value,
    input  wire logic [DATA_WIDTH-1:0] i_left,
    input  wire logic [DATA_WIDTH-1:0] i_right,
    output logic      [DATA_WIDTH-1:0] o_data
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // Pick the next word for this cell
    always_comb begin
        unique case (i_sel)
            SEL_HOLD:  n_data = r_data;
            SEL_NEW:   n_data = i_value;
            SEL_LEFT:  n_data = i_left;
            SEL_RIGHT: n_data = i_right;
        endcase
    end

    // Hold the word; no reset, contents are valid only once written
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule : iidl_cell

`default_nettype wire

// ===== hdl/indexed_insert_delete_list.sv =====
// Top level of the indexed list: command decode, fill count, cell row and response register.
//
// Bounded ordered list of up to DEPTH words, held in a row of cells.
// Request channel: i_in_valid / o_in_stall with i_command, i_position and
// i_value. A request is taken at an edge where i_in_valid is high and
// o_in_stall is low. Commands insert at the tail, the head or a position,
// remove from the head, the tail or a position, or read a position.
// Response channel: o_out_valid / i_out_stall with o_data_out, o_ok and
// o_count; one response per request, in request order.
// The response is loaded into the output register at the edge that takes
// the request. Throughput is one request per cycle when not stalled, since
// every cell shifts in the same cycle as the decode and the read select.
// While the response register holds a word the receiver stalls, o_in_stall
// is raised and no request is taken; it drops in the cycle the response
// leaves. Reset (i_rst_n low, synchronous) empties the list and drops
// o_out_valid; cell contents are not cleared and are read only once
// written.
`default_nettype none

module indexed_insert_delete_list
    import iidl_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [2:0]         i_command,
    input  wire logic [POS_W-1:0]   i_position,
    input  wire logic [WORD_W-1:0]  i_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic      [WORD_W-1:0]  o_data_out,
    output logic                    o_ok,
    output logic      [COUNT_W-1:0] o_count
);

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int IW  = $clog2(DEPTH);
    localparam int PW  = (CW > POS_W) ? CW : POS_W;
    localparam int XW  = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int DXW = (DATA_WIDTH > WORD_W) ? DATA_WIDTH : WORD_W;

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_out_valid;
    logic [WORD_W-1:0]     r_data_out;
    logic                  r_ok;
    logic [COUNT_W-1:0]    r_count_out;

    logic                  in_acc;
    t_cmd                  cmd;
    logic [PW-1:0]         pos_x;
    logic [PW-1:0]         cnt_x;
    logic [PW-1:0]         at;
    logic                  ins_ok;
    logic                  rem_ok;
    logic                  rd_ok;
    logic                  n_ok;
    logic [DXW-1:0]        val_x;
    logic [DATA_WIDTH-1:0] val;
    logic [DATA_WIDTH-1:0] rd_word;
    logic [DXW-1:0]        rd_x;
    logic [WORD_W-1:0]     n_data_out;
    logic [XW-1:0]         cnt_out_x;

    logic [DATA_WIDTH-1:0] cell_q [DEPTH];
    t_cell_sel             cell_sel [DEPTH];

    // Take a request when the response register is free or draining
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign cmd   = t_cmd'(i_command);
    assign pos_x = PW'(i_position);
    assign cnt_x = PW'(r_count);
    assign val_x = DXW'(i_value);
    assign val   = val_x[DATA_WIDTH-1:0];

    // Decode the command into a slot and an outcome
    always_comb begin
        at     = '0;
        ins_ok = 1'b0;
        rem_ok = 1'b0;
        rd_ok  = 1'b0;
        unique case (cmd)
            CMD_INS_TAIL: begin
                at     = cnt_x;
                ins_ok = (r_count != CW'(DEPTH));
            end
            CMD_INS_HEAD: begin
                at     = '0;
                ins_ok = (r_count != CW'(DEPTH));
            end
            CMD_INS_AT: begin
                at     = pos_x;
                ins_ok = (r_count != CW'(DEPTH)) && (pos_x <= cnt_x);
            end
            CMD_REM_HEAD: begin
                at     = '0;
                rem_ok = (r_count != '0);
            end
            CMD_REM_TAIL: begin
                at     = PW'(r_count - 1'b1);
                rem_ok = (r_count != '0);
            end
            CMD_REM_AT: begin
                at     = pos_x;
                rem_ok = (pos_x < cnt_x);
            end
            CMD_READ_AT: begin
                at    = pos_x;
                rd_ok = (pos_x < cnt_x);
            end
            default: begin
                at = '0;
            end
        endcase
    end

    assign n_ok = ins_ok || rem_ok || rd_ok;

    // Read the addressed cell before any shift lands
    assign rd_word    = cell_q[at[IW-1:0]];
    assign rd_x       = DXW'(rd_word);
    assign n_data_out = (rem_ok || rd_ok) ? rd_x[WORD_W-1:0] : '0;

    // Advance the fill count
    always_comb begin
        n_count = r_count;
        if (in_acc && ins_ok) begin
            n_count = r_count + 1'b1;
        end else if (in_acc && rem_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    assign cnt_out_x = XW'(n_count);

    // Row of cells: shift up behind an insert, shift down behind a remove
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_q;
        logic [DATA_WIDTH-1:0] right_q;

        if (g == 0) begin : g_first
            assign left_q = cell_q[g];
        end else begin : g_mid_l
            assign left_q = cell_q[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_q = cell_q[g];
        end else begin : g_mid_r
            assign right_q = cell_q[g+1];
        end

        always_comb begin
            cell_sel[g] = SEL_HOLD;
            if (in_acc && ins_ok) begin
                if (PW'(g) > at) begin
                    cell_sel[g] = SEL_LEFT;
                end else if (PW'(g) == at) begin
                    cell_sel[g] = SEL_NEW;
                end
            end else if (in_acc && rem_ok) begin
                if (PW'(g) >= at) begin
                    cell_sel[g] = SEL_RIGHT;
                end
            end
        end

        iidl_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_sel   (cell_sel[g]),
            .i_value (val),
            .i_left  (left_q),
            .i_right (right_q),
            .o_data  (cell_q[g])
        );
    end

    // Hold the count and the response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_acc) begin
            r_data_out  <= n_data_out;
            r_ok        <= n_ok;
            r_count_out <= cnt_out_x[COUNT_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data_out;
    assign o_ok        = r_ok;
    assign o_count     = r_count_out;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    a_resp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_out_valid)
        else $error("accepted request left no response");

    a_refused_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !ins_ok && !rem_ok) |=> (r_count == $past(r_count)))
        else $error("count moved without an insert or remove");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && ins_ok) |=> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("insert did not grow the list by one");
`endif

endmodule : indexed_insert_delete_list

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the indexed insert/delete list.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import iidl_pkg::*;

    localparam int LIST_DEPTH = 16;
    localparam int RANDOM_REQUESTS = 900;
    localparam int CYCLE_LIMIT = 300000;
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    // One response of the list
    typedef struct packed {
        logic [WORD_W-1:0]  data;
        logic               ok;
        logic [COUNT_W-1:0] count;
    } t_reply;

    // One row of the directed table; typed rows carry a hand-written reply
    typedef struct packed {
        logic [2:0]         cmd;
        logic [POS_W-1:0]   pos;
        logic [WORD_W-1:0]  val;
        logic [4:0]         reps;
        logic               typed;
        logic [WORD_W-1:0]  data;
        logic               ok;
        logic [COUNT_W-1:0] count;
    } t_stim_row;

    localparam int NUM_ROWS = 26;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [2:0]         i_command = '0;
    logic [POS_W-1:0]   i_position = '0;
    logic [WORD_W-1:0]  i_value = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [WORD_W-1:0]  o_data_out;
    logic               o_ok;
    logic [COUNT_W-1:0] o_count;

    // Shadow copy of the list contents
    logic [WORD_W-1:0]  list_words [LIST_DEPTH];
    int                 list_fill = 0;

    t_reply             replies_due [$];
    t_stim_row          stim_rows [NUM_ROWS];
    int                 mismatches = 0;
    int                 cycles = 0;
    int                 send_idle_pct = 0;
    int                 stall_pct = 0;

    indexed_insert_delete_list dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data_out  (o_data_out),
        .o_ok        (o_ok),
        .o_count     (o_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one command to the shadow list and return the reply it yields
    function automatic t_reply apply_list_command(input logic [2:0] cmd,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic [WORD_W-1:0] val);
        t_reply r;
        int     at;
        r = '0;
        at = 0;
        case (cmd)
            CMD_INS_TAIL, CMD_INS_HEAD, CMD_INS_AT: begin
                if (cmd == CMD_INS_TAIL) at = list_fill;
                else if (cmd == CMD_INS_AT) at = int'(pos);
                if (list_fill < LIST_DEPTH && at <= list_fill) begin
                    // open a gap at the insert slot
                    for (int n = list_fill; n > at; n--) list_words[n] = list_words[n-1];
                    list_words[at] = val;
                    list_fill++;
                    r.ok = 1'b1;
                end
            end
            CMD_REM_HEAD, CMD_REM_TAIL, CMD_REM_AT: begin
                if (cmd == CMD_REM_TAIL) at = list_fill - 1;
                else if (cmd == CMD_REM_AT) at = int'(pos);
                if (at >= 0 && at < list_fill) begin
                    r.data = list_words[at];
                    // close the gap left by the removed word
                    for (int n = at; n + 1 < list_fill; n++) list_words[n] = list_words[n+1];
                    list_fill--;
                    r.ok = 1'b1;
                end
            end
            CMD_READ_AT: begin
                if (int'(pos) < list_fill) begin
                    r.data = list_words[pos];
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.count = COUNT_W'(list_fill);
        return r;
    endfunction

    // Present one request, wait for it to be taken, then log its reply
    task automatic send_request(input logic [2:0] cmd, input logic [POS_W-1:0] pos,
                                input logic [WORD_W-1:0] val, input logic typed,
                                input t_reply typed_reply);
        t_reply predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_position <= pos;
        i_value    <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = apply_list_command(cmd, pos, val);
        replies_due.push_back(typed ? typed_reply : predicted);
    endtask

    // Check each reply taken by the receiver, then choose the next stall
    always @(posedge i_clk) begin : take_reply
        t_reply due;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected reply data %h ok %b count %0d",
                         $time, o_data_out, o_ok, o_count);
                mismatches++;
            end else begin
                due = replies_due.pop_front();
                if (o_data_out !== due.data) begin
                    $display("%0t: data_out expected %h actual %h", $time, due.data, o_data_out);
                    mismatches++;
                end
                if (o_ok !== due.ok) begin
                    $display("%0t: ok expected %b actual %b", $time, due.ok, o_ok);
                    mismatches++;
                end
                if (o_count !== due.count) begin
                    $display("%0t: count expected %0d actual %0d", $time, due.count, o_count);
                    mismatches++;
                end
            end
        end
        i_out_stall <= i_rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        logic [2:0]        cmd;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] val;
        int                lim;
        int                roll;
        int                phase;
        bit                growing;

        stim_rows = '{
            // empty list: reads, removes, an insert past count and an unused command refused
            '{CMD_READ_AT,  4'd0,  32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 1'b0, 5'd0},
            '{CMD_REM_HEAD, 4'd0,  32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 1'b0, 5'd0},
            '{CMD_REM_TAIL, 4'd0,  32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 1'b0, 5'd0},
            '{CMD_INS_AT,   4'd1,  32'hDEAD_BEEF, 5'd1,  1'b1, 32'h0000_0000, 1'b0, 5'd0},
            '{CMD_UNUSED,   4'd0,  32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 1'b0, 5'd0},
            // build a short list through each insert flavor, then read it
            '{CMD_INS_TAIL, 4'd0,  32'hFFFF_FFFF, 5'd1,  1'b1, 32'h0000_0000, 1'b1, 5'd1},
            '{CMD_INS_HEAD, 4'd0,  32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 1'b1, 5'd2},
            '{CMD_INS_AT,   4'd1,  32'hA5A5_A5A5, 5'd1,  1'b1, 32'h0000_0000, 1'b1, 5'd3},
            '{CMD_INS_AT,   4'd3,  32'h5A5A_5A5A, 5'd1,  1'b1, 32'h0000_0000, 1'b1, 5'd4},
            '{CMD_READ_AT,  4'd2,  32'h0000_0000, 5'd1,  1'b1, 32'hFFFF_FFFF, 1'b1, 5'd4},
            '{CMD_READ_AT,  4'd4,  32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 1'b0, 5'd4},
            // fill up, then every insert is refused
            '{CMD_INS_TAIL, 4'd0,  32'h8000_0001, 5'd12, 1'b0, 32'h0000_0000, 1'b0, 5'd0},
            '{CMD_INS_TAIL, 4'd0,  32'h0000_0001, 5'd1,  1'b1, 32'h0000_0000, 1'b0, 5'd16},
            '{CMD_INS_HEAD, 4'd0,  32'h0000_0001, 5'd1,  1'b1, 32'h0000_0000, 1'b0, 5'd16},
            '{CMD_INS_AT,   4'd0,  32'h0000_0001, 5'd1,  1'b1, 32'h0000_0000, 1'b0, 5'd16},
            '{CMD_READ_AT,  4'd15, 32'h0000_0000, 5'd1,  1'b1, 32'h8000_0001, 1'b1, 5'd16},
            // each remove flavor
            '{CMD_REM_AT,   4'd15, 32'h0000_0000, 5'd1,  1'b1, 32'h8000_0001, 1'b1, 5'd15},
            '{CMD_REM_AT,   4'd1,  32'h0000_0000, 5'd1,  1'b1, 32'hA5A5_A5A5, 1'b1, 5'd14},
            '{CMD_REM_HEAD, 4'd0,  32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 1'b1, 5'd13},
            '{CMD_REM_TAIL, 4'd0,  32'h0000_0000, 5'd1,  1'b1, 32'h8000_0001, 1'b1, 5'd12},
            '{CMD_READ_AT,  4'd0,  32'h0000_0000, 5'd1,  1'b1, 32'hFFFF_FFFF, 1'b1, 5'd12},
            // positions at and past the count
            '{CMD_REM_AT,   4'd15, 32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 1'b0, 5'd12},
            '{CMD_INS_AT,   4'd13, 32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 1'b0, 5'd12},
            '{CMD_INS_AT,   4'd12, 32'h1234_5678, 5'd1,  1'b1, 32'h0000_0000, 1'b1, 5'd13},
            '{CMD_UNUSED,   4'd15, 32'hFFFF_FFFF, 5'd1,  1'b1, 32'h0000_0000, 1'b0, 5'd13},
            '{CMD_REM_AT,   4'd12, 32'h0000_0000, 5'd1,  1'b1, 32'h1234_5678, 1'b1, 5'd12}
        };

        // hold reset, then release it on a clock edge
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the directed table
        foreach (stim_rows[r]) begin
            for (int k = 0; k < int'(stim_rows[r].reps); k++) begin
                send_request(stim_rows[r].cmd, stim_rows[r].pos, stim_rows[r].val,
                             stim_rows[r].typed,
                             '{stim_rows[r].data, stim_rows[r].ok, stim_rows[r].count});
            end
        end

        // random requests drifting between an empty and a full list
        growing = 1'b0;
        for (int k = 0; k < RANDOM_REQUESTS; k++) begin
            phase = (k / 75) % 4;
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 73; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 73; end
                default: begin send_idle_pct = 6; stall_pct = 6; end
            endcase

            roll = $urandom_range(0, 99);
            if (roll < 8) cmd = 3'($urandom_range(0, 7));
            else if (roll < 18) cmd = CMD_READ_AT;
            else if ((roll < 70) == growing) cmd = 3'($urandom_range(0, 2));
            else cmd = 3'($urandom_range(3, 5));

            // mostly legal positions, sometimes anywhere
            lim = (cmd == CMD_INS_AT) ? list_fill : list_fill - 1;
            if (lim > 15) lim = 15;
            if (lim >= 0 && $urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(0, lim));
            else pos = POS_W'($urandom_range(0, 15));

            roll = $urandom_range(0, 99);
            if (roll < 5) val = '0;
            else if (roll < 10) val = '1;
            else val = $urandom;

            send_request(cmd, pos, val, 1'b0, '0);

            if (list_fill == LIST_DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
            if (list_fill == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
            if ($urandom_range(0, 49) == 0) growing = !growing;
        end

        // drain: let every reply come back, then allow a few stray cycles
        i_in_valid <= 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule : testbench

`default_nettype wire
